FILE: rtl/core/plt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_pkg
// shared types, constants and helpers of the prefix lifetime table
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int unsigned DEFAULT_ENTRIES = 8;
  localparam int unsigned MAX_RESULTS     = 8;
  localparam int unsigned CNT_W           = $clog2(MAX_RESULTS + 1);
  localparam int unsigned SLOT_W          = 3;

  localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;

  // action codes on the result channel
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_DEMOTE = 2'd3;

  // command codes on the input channel
  localparam logic CMD_AGE    = 1'b0;
  localparam logic CMD_PREFIX = 1'b1;

  // bit positions in the stored flag nibble
  localparam int unsigned FLAG_PREF  = 0;
  localparam int unsigned FLAG_SLAAC = 1;
  localparam int unsigned FLAG_DHCP  = 2;
  localparam int unsigned FLAG_CONF  = 3;

  typedef struct packed {
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
    logic [7:0]  length;
    logic [3:0]  flags;
    logic [31:0] valid_deadline;
  } plt_entry_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       prefix_high;
    logic [63:0]       prefix_low;
    logic [7:0]        length;
    logic              preferred;
    logic              slaac;
    logic              dhcp;
    logic              configure;
    logic              last;
  } plt_result_t;

  // absolute deadline, saturating at all-ones
  function automatic logic [31:0] deadline_of(input logic [31:0] now,
                                              input logic [31:0] life);
    logic [32:0] sum;
    sum = {1'b0, now} + {1'b0, life};
    if (life == ALL32 || sum[32]) begin
      return ALL32;
    end
    return sum[31:0];
  endfunction

  // ones in the leading len bits, all ones for any length of 128 or more
  function automatic logic [127:0] prefix_mask(input logic [7:0] len);
    return ~({128{1'b1}} >> len);
  endfunction

  function automatic plt_result_t nothing_result();
    plt_result_t r;
    r      = '0;
    r.last = 1'b1;
    return r;
  endfunction

endpackage

FILE: rtl/core/plt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module plt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/prefix_lifetime_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_lifetime_table
// table of advertised ipv6 prefixes with valid and preferred deadlines
// ----------------------------------------------------------------------------
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+--------------------------------------------
//  input   | in  | in_valid_i / in_ready_o   | cmd, now, prefix, length, lifetimes, flags
//  result  | out | out_valid_o / out_ready_i | action, slot, entry fields, flags, last
//
//  an item walks the table one entry at a time (ram read, then evaluate), as set by the
//  single ram read port and the shared compare logic; an ignored prefix item skips the
//  walk and returns a nothing result.
//  reset empties the table at once: occupancy and deadline-written bits are flops.
//  in_ready_o is high only between items; an age walk parks one result beside the
//  output register and stalls when a further result finds both still full.
// ----------------------------------------------------------------------------
module prefix_lifetime_table import plt_pkg::*; #(
  parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] now_i,
  input  logic [63:0] prefix_high_i,
  input  logic [63:0] prefix_low_i,
  input  logic [7:0]  prefix_length_i,
  input  logic [31:0] valid_lifetime_i,
  input  logic [31:0] preferred_lifetime_i,
  input  logic        autoconf_flag_i,
  input  logic        managed_flag_i,
  input  logic        other_config_flag_i,
  // result item
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  action_o,
  output logic [2:0]  slot_o,
  output logic [63:0] out_prefix_high_o,
  output logic [63:0] out_prefix_low_o,
  output logic [7:0]  out_length_o,
  output logic        preferred_o,
  output logic        slaac_o,
  output logic        dhcp_o,
  output logic        configure_o,
  output logic        last_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_RESULTS - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_NONE   = 3'd5;

  // control state
  logic [2:0]         state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [ENTRIES-1:0] used_q, used_d;
  logic [ENTRIES-1:0] pdv_q, pdv_d;
  logic               out_valid_q, out_valid_d;
  logic               pend_q, pend_d;
  logic               match_q, match_d;
  logic               free_q, free_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // item and scan payload
  logic               cmd_q;
  logic [31:0]        now_q;
  logic [63:0]        hi_q;
  logic [63:0]        lo_q;
  logic [7:0]         len_q;
  logic [31:0]        vl_q;
  logic [31:0]        pl_q;
  logic               af_q, mf_q, of_q;
  logic [IDX_W-1:0]   match_idx_q, free_idx_q, best_idx_q;
  logic               best_pref_q;
  logic [31:0]        best_vd_q, best_pd_q;
  plt_result_t        out_q, out_d;
  plt_result_t        pend_res_q, pend_res_d;

  // ram ports
  logic               main_we, pd_we, ram_re;
  logic [IDX_W-1:0]   main_waddr;
  plt_entry_t         main_wdata, rd_entry;
  logic [31:0]        rd_pd;

  // shared evaluation unit
  logic               accept;
  logic               out_free;
  logic [31:0]        pd_eff;
  logic [127:0]       mask;
  logic               hit, less, expired, demote, change, stall;
  logic [IDX_W-1:0]   sel_slot;
  logic               take_best;
  plt_result_t        new_res;
  plt_entry_t         demoted_entry;
  logic [3:0]         new_flags;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign ram_re   = (state_q == S_READ);

  plt_ram #(
    .WIDTH ($bits(plt_entry_t)),
    .DEPTH (ENTRIES)
  ) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .waddr_i (main_waddr),
    .wdata_i (main_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (rd_entry)
  );

  // preferred deadline kept apart: a zero preferred lifetime leaves it alone
  plt_ram #(
    .WIDTH (32),
    .DEPTH (ENTRIES)
  ) u_pd_ram (
    .clk_i   (clk_i),
    .we_i    (pd_we),
    .waddr_i (sel_slot),
    .wdata_i (deadline_of(now_q, pl_q)),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (rd_pd)
  );

  // a preferred deadline never written reads as zero, masked by its written bit
  assign pd_eff = pdv_q[idx_q] ? rd_pd : 32'd0;
  assign mask   = prefix_mask(len_q);

  assign hit = used_q[idx_q] && (rd_entry.length == len_q)
            && (((hi_q ^ rd_entry.prefix_high) & mask[127:64]) == 64'd0)
            && (((lo_q ^ rd_entry.prefix_low) & mask[63:0]) == 64'd0);

  // eviction order: non-preferred first, then valid deadline, then preferred
  always_comb begin
    if (rd_entry.flags[FLAG_PREF] != best_pref_q) begin
      less = !rd_entry.flags[FLAG_PREF];
    end else if (rd_entry.valid_deadline != best_vd_q) begin
      less = rd_entry.valid_deadline < best_vd_q;
    end else begin
      less = pd_eff < best_pd_q;
    end
  end
  assign take_best = (idx_q == '0) || less;

  assign expired = used_q[idx_q] && (rd_entry.valid_deadline != ALL32)
                && (rd_entry.valid_deadline <= now_q);
  assign demote  = used_q[idx_q] && !expired && rd_entry.flags[FLAG_PREF]
                && (pd_eff != ALL32) && (pd_eff < now_q);
  assign change  = expired || demote;
  assign stall   = change && pend_q && !out_free;

  assign sel_slot = match_q ? match_idx_q : (free_q ? free_idx_q : best_idx_q);

  assign new_flags = {of_q, mf_q, af_q, (pl_q != 32'd0)};

  always_comb begin
    demoted_entry                  = rd_entry;
    demoted_entry.flags[FLAG_PREF] = 1'b0;
  end

  // result for the entry under evaluation in an age walk
  always_comb begin
    new_res             = '0;
    new_res.action      = expired ? ACT_REMOVE : ACT_DEMOTE;
    new_res.slot        = SLOT_W'(idx_q);
    new_res.prefix_high = rd_entry.prefix_high;
    new_res.prefix_low  = rd_entry.prefix_low;
    new_res.length      = rd_entry.length;
    new_res.preferred   = expired ? rd_entry.flags[FLAG_PREF] : 1'b0;
    new_res.slaac       = rd_entry.flags[FLAG_SLAAC];
    new_res.dhcp        = rd_entry.flags[FLAG_DHCP];
    new_res.configure   = rd_entry.flags[FLAG_CONF];
    new_res.last        = 1'b0;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    used_d      = used_q;
    pdv_d       = pdv_q;
    pend_d      = pend_q;
    match_d     = match_q;
    free_d      = free_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    pend_res_d  = pend_res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    main_we     = 1'b0;
    main_waddr  = idx_q;
    main_wdata  = demoted_entry;
    pd_we       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          match_d = 1'b0;
          free_d  = 1'b0;
          pend_d  = 1'b0;
          cnt_d   = '0;
          if (cmd_i == CMD_PREFIX && valid_lifetime_i == 32'd0) begin
            state_d = S_NONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (cmd_q == CMD_PREFIX) begin
          if (hit) begin
            match_d = 1'b1;
            state_d = S_WRITE;
          end else begin
            if (!used_q[idx_q] && !free_q) begin
              free_d = 1'b1;
            end
            if (idx_q == LAST_IDX) begin
              state_d = S_WRITE;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_READ;
            end
          end
        end else if (!stall) begin
          if (change) begin
            if (pend_q) begin
              out_d       = pend_res_q;
              out_valid_d = 1'b1;
            end
            pend_res_d = new_res;
            pend_d     = 1'b1;
            cnt_d      = cnt_q + 1'b1;
            if (expired) begin
              used_d[idx_q] = 1'b0;
            end else begin
              main_we = 1'b1;
            end
          end
          if ((change && cnt_q == LAST_CNT) || idx_q == LAST_IDX) begin
            state_d = S_FINISH;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_WRITE: begin
        if (out_free) begin
          main_we                   = 1'b1;
          main_waddr                = sel_slot;
          main_wdata.prefix_high    = hi_q;
          main_wdata.prefix_low     = lo_q;
          main_wdata.length         = len_q;
          main_wdata.flags          = new_flags;
          main_wdata.valid_deadline = deadline_of(now_q, vl_q);
          used_d[sel_slot]          = 1'b1;
          if (pl_q != 32'd0) begin
            pd_we           = 1'b1;
            pdv_d[sel_slot] = 1'b1;
          end
          out_d.action      = ACT_ADD;
          out_d.slot        = SLOT_W'(sel_slot);
          out_d.prefix_high = hi_q;
          out_d.prefix_low  = lo_q;
          out_d.length      = len_q;
          out_d.preferred   = new_flags[FLAG_PREF];
          out_d.slaac       = new_flags[FLAG_SLAAC];
          out_d.dhcp        = new_flags[FLAG_DHCP];
          out_d.configure   = new_flags[FLAG_CONF];
          out_d.last        = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          if (pend_q) begin
            out_d      = pend_res_q;
            out_d.last = 1'b1;
          end else begin
            out_d = nothing_result();
          end
          pend_d      = 1'b0;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_NONE: begin
        if (out_free) begin
          out_d       = nothing_result();
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      used_q      <= '0;
      pdv_q       <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      used_q      <= used_d;
      pdv_q       <= pdv_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      match_q     <= match_d;
      free_q      <= free_d;
      cnt_q       <= cnt_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    pend_res_q <= pend_res_d;
    if (accept) begin
      cmd_q <= cmd_i;
      now_q <= now_i;
      hi_q  <= prefix_high_i;
      lo_q  <= prefix_low_i;
      len_q <= prefix_length_i;
      vl_q  <= valid_lifetime_i;
      pl_q  <= preferred_lifetime_i;
      af_q  <= autoconf_flag_i;
      mf_q  <= managed_flag_i;
      of_q  <= other_config_flag_i;
    end
    if (state_q == S_EVAL && cmd_q == CMD_PREFIX) begin
      if (hit) begin
        match_idx_q <= idx_q;
      end
      if (!used_q[idx_q] && !free_q) begin
        free_idx_q <= idx_q;
      end
      if (take_best) begin
        best_idx_q  <= idx_q;
        best_pref_q <= rd_entry.flags[FLAG_PREF];
        best_vd_q   <= rd_entry.valid_deadline;
        best_pd_q   <= pd_eff;
      end
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign action_o          = out_q.action;
  assign slot_o            = out_q.slot;
  assign out_prefix_high_o = out_q.prefix_high;
  assign out_prefix_low_o  = out_q.prefix_low;
  assign out_length_o      = out_q.length;
  assign preferred_o       = out_q.preferred;
  assign slaac_o           = out_q.slaac;
  assign dhcp_o            = out_q.dhcp;
  assign configure_o       = out_q.configure;
  assign last_o            = out_q.last;

endmodule
